// File: rtl/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_TEXT      = 7'b0000010,
    PH_ESC       = 7'b0000100,
    PH_HEX_FIRST = 7'b0001000,
    PH_WAIT_BSL  = 7'b0010000,
    PH_WAIT_U    = 7'b0100000,
    PH_HEX_LOW   = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_CLOSED = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_BAD_QUOTE    = 3'd1,
    ERR_BAD_ESCAPE   = 3'd2,
    ERR_BAD_HEX      = 3'd3,
    ERR_LONE_HIGH    = 3'd4,
    ERR_LONE_LOW     = 3'd5,
    ERR_UNTERMINATED = 3'd6
  } err_t;

  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam int MAX_BURST = 4;

  typedef struct packed {
    phase_t      phase;
    logic        single_quoted;
    logic [11:0] hex_accum;
    logic [1:0]  hex_count;
    logic [9:0]  high_surrogate;
  } dec_state_t;

  // Results caused by one request; bytes[0] goes out first.
  typedef struct packed {
    logic [MAX_BURST-1:0][7:0] bytes;
    logic [2:0]                count;
    kind_t                     kind;
    err_t                      err;
  } burst_t;

endpackage

// File: rtl/json_string_unescape_utf8_unit.sv
// JSON string unescaper with UTF-8 output. Source bytes enter on the in channel,
// one per request, and each is decoded in the cycle it is accepted; the up to four
// results it causes (decoded bytes, a close marker or an error) are held in a burst
// register and leave on the out channel one per cycle while out_stall is low, with
// last set on the final one. A new source byte is accepted in the same cycle as the
// final result of the previous burst, so bytes that give one result or none flow at
// one per cycle while out_stall is low; a byte that gives several results holds off
// the next byte until its final result leaves. Bytes with no string open are dropped.
module json_string_unescape_utf8_unit
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       string_start,
  input  logic       source_ended,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [2:0] error_code,
  output logic       last
);

  dec_state_t                st;
  dec_state_t                st_next;
  burst_t                    bur;
  logic [MAX_BURST-1:0][7:0] bytes;
  logic [2:0]                remain;
  kind_t                     res_kind;
  err_t                      res_err;
  logic                      in_take;
  logic                      pop;

  jsu_decoder u_dec (
    .st           (st),
    .in_byte      (in_byte),
    .string_start (string_start),
    .source_ended (source_ended),
    .st_next      (st_next),
    .bur          (bur)
  );

  assign out_valid = (remain != 3'd0);
  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((remain == 3'd0) || (remain == 3'd1 && !out_stall));
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase          <= PH_IDLE;
      st.single_quoted  <= 1'b0;
      st.hex_accum      <= '0;
      st.hex_count      <= '0;
      st.high_surrogate <= '0;
      remain            <= 3'd0;
    end else if (in_take) begin
      st     <= st_next;
      remain <= bur.count;
    end else if (pop) begin
      remain <= remain - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      bytes    <= bur.bytes;
      res_kind <= bur.kind;
      res_err  <= bur.err;
    end else if (pop) begin
      bytes <= {8'h00, bytes[MAX_BURST-1:1]};
    end
  end

  assign out_byte   = bytes[0];
  assign kind       = res_kind;
  assign error_code = res_err;
  assign last       = (remain == 3'd1);

endmodule

// File: rtl/jsu_decoder.sv
module jsu_decoder
  import jsu_pkg::*;
(
  input  dec_state_t  st,
  input  logic [7:0]  in_byte,
  input  logic        string_start,
  input  logic        source_ended,
  output dec_state_t  st_next,
  output burst_t      bur
);

  function automatic burst_t encode(input logic [20:0] cp);
    burst_t b;
    b = '0;
    b.kind = KIND_BYTE;
    b.err  = ERR_NONE;
    if (cp < 21'h80) begin
      b.bytes[0] = cp[7:0];
      b.count    = 3'd1;
    end else if (cp < 21'h800) begin
      b.bytes[0] = {3'b110, cp[10:6]};
      b.bytes[1] = {2'b10, cp[5:0]};
      b.count    = 3'd2;
    end else if (cp < 21'h10000) begin
      b.bytes[0] = {4'b1110, cp[15:12]};
      b.bytes[1] = {2'b10, cp[11:6]};
      b.bytes[2] = {2'b10, cp[5:0]};
      b.count    = 3'd3;
    end else begin
      b.bytes[0] = {5'b11110, cp[20:18]};
      b.bytes[1] = {2'b10, cp[17:12]};
      b.bytes[2] = {2'b10, cp[11:6]};
      b.bytes[3] = {2'b10, cp[5:0]};
      b.count    = 3'd4;
    end
    return b;
  endfunction

  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] cp_hex;
  logic [20:0] cp_pair;
  logic        is_high;
  logic        is_low;
  logic        fail;
  err_t        fail_code;
  logic [7:0]  close_quote;

  always_comb begin
    digit_ok = 1'b1;
    case (in_byte) inside
      [8'h30:8'h39]: digit = in_byte[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: digit = in_byte[3:0] + 4'd9;
      default: begin
        digit    = 4'd0;
        digit_ok = 1'b0;
      end
    endcase
  end

  assign cp_hex  = {st.hex_accum, digit};
  assign cp_pair = 21'h10000 + {1'b0, st.high_surrogate, cp_hex[9:0]};
  assign is_high = (cp_hex[15:10] == 6'b110110);
  assign is_low  = (cp_hex[15:10] == 6'b110111);
  assign close_quote = st.single_quoted ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    st_next   = st;
    bur       = '0;
    bur.kind  = KIND_BYTE;
    bur.err   = ERR_NONE;
    fail      = 1'b0;
    fail_code = ERR_NONE;

    if (source_ended) begin
      fail = (st.phase != PH_IDLE);
      unique case (st.phase)
        PH_IDLE:                  fail_code = ERR_NONE;
        PH_ESC:                   fail_code = ERR_BAD_ESCAPE;
        PH_HEX_FIRST, PH_HEX_LOW: fail_code = ERR_BAD_HEX;
        PH_WAIT_BSL, PH_WAIT_U:   fail_code = ERR_LONE_HIGH;
        PH_TEXT:                  fail_code = ERR_UNTERMINATED;
        default:                  fail_code = ERR_UNTERMINATED;
      endcase
    end else if (string_start) begin
      st_next.hex_accum = '0;
      st_next.hex_count = '0;
      if (in_byte == CH_DQUOTE || in_byte == CH_SQUOTE) begin
        st_next.single_quoted = (in_byte == CH_SQUOTE);
        st_next.phase         = PH_TEXT;
      end else begin
        fail      = 1'b1;
        fail_code = ERR_BAD_QUOTE;
      end
    end else begin
      unique case (st.phase)
        PH_IDLE: ;
        PH_TEXT: begin
          if (in_byte == close_quote) begin
            st_next.phase = PH_IDLE;
            bur.count     = 3'd1;
            bur.kind      = KIND_CLOSED;
          end else if (in_byte == CH_BACKSLASH) begin
            st_next.phase = PH_ESC;
          end else begin
            bur.bytes[0] = in_byte;
            bur.count    = 3'd1;
          end
        end
        PH_ESC: begin
          st_next.phase = PH_TEXT;
          bur.count     = 3'd1;
          case (in_byte) inside
            CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH, CH_SLASH: bur.bytes[0] = in_byte;
            CH_B: bur.bytes[0] = 8'h08;
            CH_F: bur.bytes[0] = 8'h0C;
            CH_N: bur.bytes[0] = 8'h0A;
            CH_R: bur.bytes[0] = 8'h0D;
            CH_T: bur.bytes[0] = 8'h09;
            CH_U: begin
              bur.count         = 3'd0;
              st_next.phase     = PH_HEX_FIRST;
              st_next.hex_accum = '0;
              st_next.hex_count = '0;
            end
            default: begin
              fail      = 1'b1;
              fail_code = ERR_BAD_ESCAPE;
            end
          endcase
        end
        PH_WAIT_BSL: begin
          if (in_byte == CH_BACKSLASH) begin
            st_next.phase = PH_WAIT_U;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_LONE_HIGH;
          end
        end
        PH_WAIT_U: begin
          if (in_byte == CH_U) begin
            st_next.phase     = PH_HEX_LOW;
            st_next.hex_accum = '0;
            st_next.hex_count = '0;
          end else begin
            fail      = 1'b1;
            fail_code = ERR_LONE_HIGH;
          end
        end
        PH_HEX_FIRST, PH_HEX_LOW: begin
          if (!digit_ok) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_HEX;
          end else if (st.hex_count != 2'd3) begin
            st_next.hex_accum = cp_hex[11:0];
            st_next.hex_count = st.hex_count + 2'd1;
          end else begin
            st_next.hex_accum = '0;
            st_next.hex_count = '0;
            if (st.phase == PH_HEX_FIRST) begin
              if (is_high) begin
                st_next.high_surrogate = cp_hex[9:0];
                st_next.phase          = PH_WAIT_BSL;
              end else if (is_low) begin
                fail      = 1'b1;
                fail_code = ERR_LONE_LOW;
              end else begin
                st_next.phase = PH_TEXT;
                bur           = encode({5'd0, cp_hex});
              end
            end else if (!is_low) begin
              fail      = 1'b1;
              fail_code = ERR_LONE_HIGH;
            end else begin
              st_next.phase = PH_TEXT;
              bur           = encode(cp_pair);
            end
          end
        end
        default: ;
      endcase
    end

    // Any error closes the string and leaves a single error result.
    if (fail) begin
      st_next.phase     = PH_IDLE;
      st_next.hex_accum = '0;
      st_next.hex_count = '0;
      bur               = '0;
      bur.count         = 3'd1;
      bur.kind          = KIND_ERROR;
      bur.err           = fail_code;
    end
  end

endmodule

// File: rtl/jsu_checker.sv
module jsu_checker
  import jsu_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [1:0] kind,
  input logic [2:0] error_code,
  input logic       last
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind)
      && $stable(error_code) && $stable(last))
    else $error("stalled result changed");

  // A burst that is not finished continues with another decoded byte.
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid && kind == KIND_BYTE)
    else $error("burst ended early");

  // Close and error markers stand alone and carry a zero byte.
  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BYTE |-> last && out_byte == 8'h00)
    else $error("marker result malformed");

  // An error code is present exactly on error results.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE))
      && kind != 2'd3 && error_code != 3'd7)
    else $error("error code does not match kind");

  // A new request is never taken while more than the final result is pending.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("request accepted during burst");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .kind       (kind),
  .error_code (error_code),
  .last       (last)
);

// File: tb/sv/json_string_unescape_utf8_unit_tb.sv
module json_string_unescape_utf8_unit_tb;
  import jsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CTL_BS     = 8'h08;
  localparam logic [7:0] CTL_HT     = 8'h09;
  localparam logic [7:0] CTL_LF     = 8'h0A;
  localparam logic [7:0] CTL_FF     = 8'h0C;
  localparam logic [7:0] CTL_CR     = 8'h0D;
  localparam logic [4:0] NOT_HEX    = 5'd16;

  localparam logic [15:0] HI_MIN = 16'hD800;
  localparam logic [15:0] HI_MAX = 16'hDBFF;
  localparam logic [15:0] LO_MIN = 16'hDC00;
  localparam logic [15:0] LO_MAX = 16'hDFFF;

  localparam logic [7:0] SIMPLE_ESC [9] = '{CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH, CH_SLASH,
                                            CH_B, CH_F, CH_N, CH_R, CH_T};

  localparam int HOLD_AT    = 200;
  localparam int HOLD_LEN   = 60;
  localparam int SRC_ITEMS  = 330;
  localparam int DRAIN_CYC  = 16;

  typedef struct packed {
    logic [7:0] b;
    kind_t      k;
    err_t       e;
    logic       l;
  } res_t;

  // A request, plus the result typed in by hand where there is one (tn says 0 or 1).
  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       en;
    logic       typed;
    logic       tn;
    kind_t      tk;
    err_t       te;
    logic [7:0] tbyte;
  } stim_t;

  localparam int NDIR = 28;
  localparam stim_t DIR_TAB [NDIR] = '{
    '{8'h61,        1'b0, 1'b0, 1'b1, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{8'h00,        1'b0, 1'b1, 1'b1, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{8'h78,        1'b1, 1'b0, 1'b1, 1'b1, KIND_ERROR,  ERR_BAD_QUOTE,    8'h00},
    '{CH_DQUOTE,    1'b1, 1'b0, 1'b1, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{8'h00,        1'b0, 1'b0, 1'b1, 1'b1, KIND_BYTE,   ERR_NONE,         8'h00},
    '{8'hFF,        1'b0, 1'b0, 1'b1, 1'b1, KIND_BYTE,   ERR_NONE,         8'hFF},
    '{CH_SQUOTE,    1'b0, 1'b0, 1'b1, 1'b1, KIND_BYTE,   ERR_NONE,         CH_SQUOTE},
    '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{CH_N,         1'b0, 1'b0, 1'b1, 1'b1, KIND_BYTE,   ERR_NONE,         CTL_LF},
    '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{CH_U,         1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{"D",          1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{"B",          1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{"F",          1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{"f",          1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{CH_U,         1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{"d",          1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{"F",          1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{"F",          1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{"F",          1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{CH_BACKSLASH, 1'b0, 1'b0, 1'b0, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{8'h71,        1'b0, 1'b0, 1'b1, 1'b1, KIND_ERROR,  ERR_BAD_ESCAPE,   8'h00},
    '{CH_SQUOTE,    1'b1, 1'b0, 1'b1, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{CH_SQUOTE,    1'b1, 1'b0, 1'b1, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{CH_SQUOTE,    1'b0, 1'b0, 1'b1, 1'b1, KIND_CLOSED, ERR_NONE,         8'h00},
    '{CH_DQUOTE,    1'b1, 1'b0, 1'b1, 1'b0, KIND_BYTE,   ERR_NONE,         8'h00},
    '{8'hFF,        1'b1, 1'b1, 1'b1, 1'b1, KIND_ERROR,  ERR_UNTERMINATED, 8'h00}
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte;
  logic       string_start;
  logic       source_ended;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last;

  stim_t cur;
  stim_t src_q [$];
  res_t  decoded_q [$];
  res_t  step_out [$];
  int    src_cnt;
  int    taken_cnt;
  int    mismatch_cnt;
  bit    calm;

  // Decoder state mirrored by the scoreboard.
  phase_t      dphase;
  logic        dsq;
  logic [15:0] dacc;
  logic [1:0]  dcnt;
  logic [9:0]  dhigh;

  json_string_unescape_utf8_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .string_start (string_start),
    .source_ended (source_ended),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .kind         (kind),
    .error_code   (error_code),
    .last         (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 35);
  endfunction

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return 5'(c - CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_F) return 5'(c - CH_LOWER_A + 8'd10);
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) return 5'(c - CH_UPPER_A + 8'd10);
    return NOT_HEX;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return CH_ZERO + {4'h0, n};
    return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + {4'h0, n - 4'd10};
  endfunction

  task automatic emit(input logic [7:0] b, input kind_t k, input err_t e);
    step_out.push_back(res_t'{b, k, e, 1'b0});
  endtask

  task automatic abort(input err_t e);
    dphase = PH_IDLE;
    dacc = '0;
    dcnt = '0;
    emit(8'h00, KIND_ERROR, e);
  endtask

  task automatic put_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit(cp[7:0], KIND_BYTE, ERR_NONE);
    end else if (cp < 21'h800) begin
      emit({3'b110, cp[10:6]}, KIND_BYTE, ERR_NONE);
      emit({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end else if (cp < 21'h10000) begin
      emit({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NONE);
      emit({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
      emit({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end else begin
      emit({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NONE);
      emit({2'b10, cp[17:12]}, KIND_BYTE, ERR_NONE);
      emit({2'b10, cp[11:6]}, KIND_BYTE, ERR_NONE);
      emit({2'b10, cp[5:0]}, KIND_BYTE, ERR_NONE);
    end
  endtask

  // Computes the results of one source byte into step_out and advances the state.
  task automatic unescape_byte(input logic [7:0] c, input logic st, input logic en);
    logic [4:0]  d;
    logic [15:0] cp;
    step_out.delete();
    if (en) begin
      case (dphase)
        PH_IDLE: ;
        PH_ESC: abort(ERR_BAD_ESCAPE);
        PH_HEX_FIRST, PH_HEX_LOW: abort(ERR_BAD_HEX);
        PH_WAIT_BSL, PH_WAIT_U: abort(ERR_LONE_HIGH);
        default: abort(ERR_UNTERMINATED);
      endcase
    end else if (st) begin
      dacc = '0;
      dcnt = '0;
      if (c != CH_DQUOTE && c != CH_SQUOTE) begin
        abort(ERR_BAD_QUOTE);
      end else begin
        dsq = (c == CH_SQUOTE);
        dphase = PH_TEXT;
      end
    end else begin
      case (dphase)
        PH_TEXT: begin
          if (c == (dsq ? CH_SQUOTE : CH_DQUOTE)) begin
            dphase = PH_IDLE;
            emit(8'h00, KIND_CLOSED, ERR_NONE);
          end else if (c == CH_BACKSLASH) begin
            dphase = PH_ESC;
          end else begin
            emit(c, KIND_BYTE, ERR_NONE);
          end
        end
        PH_ESC: begin
          dphase = PH_TEXT;
          case (c)
            CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH, CH_SLASH: emit(c, KIND_BYTE, ERR_NONE);
            CH_B: emit(CTL_BS, KIND_BYTE, ERR_NONE);
            CH_F: emit(CTL_FF, KIND_BYTE, ERR_NONE);
            CH_N: emit(CTL_LF, KIND_BYTE, ERR_NONE);
            CH_R: emit(CTL_CR, KIND_BYTE, ERR_NONE);
            CH_T: emit(CTL_HT, KIND_BYTE, ERR_NONE);
            CH_U: begin
              dphase = PH_HEX_FIRST;
              dacc = '0;
              dcnt = '0;
            end
            default: abort(ERR_BAD_ESCAPE);
          endcase
        end
        PH_WAIT_BSL: begin
          if (c != CH_BACKSLASH) abort(ERR_LONE_HIGH);
          else dphase = PH_WAIT_U;
        end
        PH_WAIT_U: begin
          if (c != CH_U) begin
            abort(ERR_LONE_HIGH);
          end else begin
            dphase = PH_HEX_LOW;
            dacc = '0;
            dcnt = '0;
          end
        end
        PH_HEX_FIRST, PH_HEX_LOW: begin
          d = hex_val(c);
          if (d == NOT_HEX) begin
            abort(ERR_BAD_HEX);
          end else begin
            cp = {dacc[11:0], d[3:0]};
            if (dcnt < 2'd3) begin
              dacc = cp;
              dcnt = dcnt + 2'd1;
            end else begin
              dacc = '0;
              dcnt = '0;
              if (dphase == PH_HEX_FIRST) begin
                if (cp >= HI_MIN && cp <= HI_MAX) begin
                  dhigh = cp[9:0];
                  dphase = PH_WAIT_BSL;
                end else if (cp >= LO_MIN && cp <= LO_MAX) begin
                  abort(ERR_LONE_LOW);
                end else begin
                  dphase = PH_TEXT;
                  put_utf8({5'd0, cp});
                end
              end else if (cp < LO_MIN || cp > LO_MAX) begin
                abort(ERR_LONE_HIGH);
              end else begin
                dphase = PH_TEXT;
                put_utf8(21'h10000 + {1'b0, dhigh, cp[9:0]});
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].l = 1'b1;
  endtask

  task automatic report(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : score
    res_t got;
    res_t want;
    if (rst) begin
      dphase = PH_IDLE;
      dsq = 1'b0;
      dacc = '0;
      dcnt = '0;
      dhigh = '0;
    end else begin
      if (in_valid && !in_stall) begin
        unescape_byte(in_byte, string_start, source_ended);
        if (cur.typed) begin
          if (cur.tn) decoded_q.push_back(res_t'{cur.tbyte, cur.tk, cur.te, 1'b1});
        end else begin
          foreach (step_out[i]) decoded_q.push_back(step_out[i]);
        end
        taken_cnt <= taken_cnt + 1;
      end
      if (out_valid && !out_stall) begin
        got = res_t'{out_byte, kind_t'(kind), err_t'(error_code), last};
        if (decoded_q.size() == 0) begin
          report($sformatf("unexpected result: byte %02h kind %0d err %0d last %0d",
                           got.b, got.k, got.e, got.l));
        end else begin
          want = decoded_q.pop_front();
          if (got.b !== want.b || got.k !== want.k || got.e !== want.e || got.l !== want.l) begin
            report($sformatf({"mismatch: expected byte %02h kind %0d err %0d last %0d,",
                              " got byte %02h kind %0d err %0d last %0d"},
                             want.b, want.k, want.e, want.l, got.b, got.k, got.e, got.l));
          end
        end
      end
    end
  end

  task automatic feed(input logic [7:0] b, input logic st, input logic en);
    src_q.push_back(stim_t'{b, st, en, 1'b0, 1'b0, KIND_BYTE, ERR_NONE, 8'h00});
    src_cnt++;
  endtask

  task automatic feed_u(input logic [15:0] v);
    feed(CH_BACKSLASH, 1'b0, 1'b0);
    feed(CH_U, 1'b0, 1'b0);
    for (int k = 3; k >= 0; k--) feed(hex_char(v[k*4 +: 4]), 1'b0, 1'b0);
  endtask

  task automatic send(input stim_t s);
    if (idle_now()) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (idle_now());
    end
    in_valid     <= 1'b1;
    in_byte      <= s.b;
    string_start <= s.st;
    source_ended <= s.en;
    cur          <= s;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    logic [7:0]  q;
    logic [7:0]  v8;
    logic [15:0] v16;
    int          pick;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_byte      = 8'h00;
    string_start = 1'b0;
    source_ended = 1'b0;
    cur          = '0;
    calm         = 1'b0;
    taken_cnt    = 0;
    mismatch_cnt = 0;
    src_cnt      = 0;

    // Mostly well-formed strings with random content; the rest are broken strings and noise.
    while (src_cnt < SRC_ITEMS) begin
      pick = $urandom_range(99);
      q = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
      if (pick < 75) begin
        feed(q, 1'b1, 1'b0);
        repeat ($urandom_range(6, 1)) begin
          case ($urandom_range(9))
            0, 1, 2, 3: begin
              do v8 = 8'($urandom_range(255)); while (v8 == q || v8 == CH_BACKSLASH);
              feed(v8, 1'b0, 1'b0);
            end
            4, 5: begin
              feed(CH_BACKSLASH, 1'b0, 1'b0);
              feed(SIMPLE_ESC[$urandom_range(8)], 1'b0, 1'b0);
            end
            6, 7: begin
              case ($urandom_range(2))
                0: v16 = 16'($urandom_range(16'h7F, 0));
                1: v16 = 16'($urandom_range(16'h7FF, 16'h80));
                default: begin
                  do v16 = 16'($urandom_range(16'hFFFF, 16'h800));
                  while (v16 >= HI_MIN && v16 <= LO_MAX);
                end
              endcase
              feed_u(v16);
            end
            default: begin
              feed_u(16'($urandom_range(HI_MAX, HI_MIN)));
              feed_u(16'($urandom_range(LO_MAX, LO_MIN)));
            end
          endcase
        end
        if ($urandom_range(9) == 0) feed(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        else feed(q, 1'b0, 1'b0);
      end else if (pick < 92) begin
        feed(q, 1'b1, 1'b0);
        case ($urandom_range(9))
          0: begin
            feed(CH_BACKSLASH, 1'b0, 1'b0);
            do v8 = 8'($urandom_range(255));
            while (v8 inside {CH_DQUOTE, CH_SQUOTE, CH_BACKSLASH, CH_SLASH,
                              CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
            feed(v8, 1'b0, 1'b0);
          end
          1: begin
            feed(CH_BACKSLASH, 1'b0, 1'b0);
            feed(CH_U, 1'b0, 1'b0);
            repeat ($urandom_range(3)) feed(hex_char(4'($urandom_range(15))), 1'b0, 1'b0);
            do v8 = 8'($urandom_range(255)); while (hex_val(v8) != NOT_HEX);
            feed(v8, 1'b0, 1'b0);
          end
          2: feed_u(16'($urandom_range(LO_MAX, LO_MIN)));
          3: begin
            feed_u(16'($urandom_range(HI_MAX, HI_MIN)));
            do v8 = 8'($urandom_range(255)); while (v8 == CH_BACKSLASH);
            feed(v8, 1'b0, 1'b0);
          end
          4: begin
            feed_u(16'($urandom_range(HI_MAX, HI_MIN)));
            feed(CH_BACKSLASH, 1'b0, 1'b0);
            do v8 = 8'($urandom_range(255)); while (v8 == CH_U);
            feed(v8, 1'b0, 1'b0);
          end
          5: begin
            feed_u(16'($urandom_range(HI_MAX, HI_MIN)));
            do v16 = 16'($urandom_range(16'hFFFF)); while (v16 >= LO_MIN && v16 <= LO_MAX);
            feed_u(v16);
          end
          6: begin
            feed(CH_BACKSLASH, 1'b0, 1'b0);
            feed(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
          end
          7: begin
            feed(CH_BACKSLASH, 1'b0, 1'b0);
            feed(CH_U, 1'b0, 1'b0);
            repeat ($urandom_range(3)) feed(hex_char(4'($urandom_range(15))), 1'b0, 1'b0);
            feed(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
          end
          8: begin
            feed_u(16'($urandom_range(HI_MAX, HI_MIN)));
            if ($urandom_range(1)) feed(CH_BACKSLASH, 1'b0, 1'b0);
            feed(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
          end
          default: begin
            if ($urandom_range(1)) feed(8'($urandom_range(255)), 1'b0, 1'b0);
            feed(8'($urandom_range(255)), 1'b1, 1'b0);
          end
        endcase
      end else begin
        // A byte with no string open is dropped, so it is not counted as work.
        feed(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        src_cnt--;
        do v8 = 8'($urandom_range(255)); while (v8 == CH_DQUOTE || v8 == CH_SQUOTE);
        feed(v8, 1'b1, 1'b0);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (DIR_TAB[i]) send(DIR_TAB[i]);
    foreach (src_q[i]) begin
      calm <= (i >= 40 && i < 110);
      send(src_q[i]);
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Output side: random back-pressure plus one long hold-off so the input side backs up.
  initial begin
    bit held_off;
    held_off  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held_off && taken_cnt >= HOLD_AT) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      out_stall <= idle_now();
    end
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: json_string_unescape_utf8_unit.f
rtl/jsu_pkg.sv
rtl/jsu_decoder.sv
rtl/json_string_unescape_utf8_unit.sv
rtl/jsu_checker.sv
tb/sv/json_string_unescape_utf8_unit_tb.sv
